// ===== hw/rtl/ltrie_pkg.sv =====
// package: types, codes and defaults for the letter trie
`default_nettype none

package ltrie_pkg;

   localparam int NODE_COUNT_DEFAULT    = 1024;
   localparam int ALPHABET_SIZE_DEFAULT = 26;

   localparam logic [1:0] MODE_INSERT = 2'd0;
   localparam logic [1:0] MODE_SEARCH = 2'd1;
   localparam logic [1:0] MODE_DELETE = 2'd2;

   typedef struct packed {
      logic [1:0] mode;
      logic [4:0] letter;
      logic       has_letter;
      logic       last;
   } req_type;

   typedef struct packed {
      logic found;
      logic pool_full;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WALK,
      ST_FINISH,
      ST_LOOKUP
   } state_type;

endpackage

`default_nettype wire

// ===== hw/rtl/letter_trie_insert_search_delete.sv =====
// top level: letter trie with insert, search and delete over a fixed node pool
//
// usage: a word arrives one letter per req transfer (req_data), with its mode on
// every item; the item with last set closes the word and yields exactly one rsp
// transfer (found for search, pool_full for insert, both zero for delete).
// items without a letter or with a letter beyond the alphabet only carry last.
// sequence: an item with a letter reads the child table, then follows or
// allocates (ST_WALK); an item without a letter, or any item once the path
// is missing, needs no table read. the closing item then writes the mark
// for insert and delete (ST_FINISH) and reads it for search (ST_FINISH, then
// ST_LOOKUP), all set by the single read port of the child and mark tables.
// the result sits in an output register; the next item is taken while it
// waits. a closing item whose result finds that register still held waits for
// the receiver, and req_stall stays high meanwhile.
// reset: a clearing pass writes zero to every child slot, one slot a cycle,
// NODE_COUNT*ALPHABET_SIZE slots (26624 by default); the mark table is cleared
// in the same pass. req_stall is high throughout the pass.
`default_nettype none

module letter_trie_insert_search_delete #(
   parameter int NODE_COUNT    = ltrie_pkg::NODE_COUNT_DEFAULT,
   parameter int ALPHABET_SIZE = ltrie_pkg::ALPHABET_SIZE_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire ltrie_pkg::req_type req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output ltrie_pkg::rsp_type      rsp_data
);

   localparam int NODE_W    = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
   localparam int SLOTS     = NODE_COUNT * ALPHABET_SIZE;
   localparam int ADDR_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int FREE_W    = NODE_W + 1;

   ltrie_pkg::state_type state_ff, state_in;
   ltrie_pkg::req_type   item_ff, item_in;
   ltrie_pkg::rsp_type   rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]    addr_ff, addr_in;
   logic [ADDR_W-1:0]    clear_ff, clear_in;
   logic [NODE_W-1:0]    cursor_ff, cursor_in;
   logic [FREE_W-1:0]    free_ff, free_in;
   logic                 missing_ff, missing_in;

   logic                 child_wr_en, child_rd_en;
   logic [ADDR_W-1:0]    child_wr_addr, walk_addr;
   logic [NODE_W-1:0]    child_wr_data, child_rd_data;
   logic                 mark_wr_en, mark_rd_en, mark_wr_data, mark_rd_data;
   logic [NODE_W-1:0]    mark_wr_addr;
   logic                 accept, out_ok, in_range, walk, pool_left;
   logic                 is_insert, is_delete;

   ltrie_ram #(.WIDTH(NODE_W), .DEPTH(SLOTS)) u_child (
      .clock   (clock),
      .wr_en   (child_wr_en),
      .wr_addr (child_wr_addr),
      .wr_data (child_wr_data),
      .rd_en   (child_rd_en),
      .rd_addr (walk_addr),
      .rd_data (child_rd_data)
   );

   ltrie_ram #(.WIDTH(1), .DEPTH(NODE_COUNT)) u_mark (
      .clock   (clock),
      .wr_en   (mark_wr_en),
      .wr_addr (mark_wr_addr),
      .wr_data (mark_wr_data),
      .rd_en   (mark_rd_en),
      .rd_addr (cursor_ff),
      .rd_data (mark_rd_data)
   );

   assign req_stall = (state_ff != ltrie_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_ok    = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign in_range  = (32'(req_data.letter) < ALPHABET_SIZE);
   assign walk      = req_data.has_letter && in_range && !missing_ff;
   assign walk_addr = ADDR_W'(32'(cursor_ff) * 32'(ALPHABET_SIZE) + 32'(req_data.letter));
   assign pool_left = (32'(free_ff) < NODE_COUNT);
   assign is_insert = (item_ff.mode == ltrie_pkg::MODE_INSERT);
   assign is_delete = (item_ff.mode == ltrie_pkg::MODE_DELETE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ltrie_pkg::ST_CLEAR;
         clear_ff     <= '0;
         cursor_ff    <= '0;
         free_ff      <= FREE_W'(1);
         missing_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clear_ff     <= clear_in;
         cursor_ff    <= cursor_in;
         free_ff      <= free_in;
         missing_ff   <= missing_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      addr_ff <= addr_in;
      rsp_ff  <= rsp_in;
   end

   always_comb begin
      state_in      = state_ff;
      item_in       = item_ff;
      addr_in       = addr_ff;
      clear_in      = clear_ff;
      cursor_in     = cursor_ff;
      free_in       = free_ff;
      missing_in    = missing_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      child_wr_en   = 1'b0;
      child_wr_addr = addr_ff;
      child_wr_data = NODE_W'(free_ff);
      child_rd_en   = 1'b0;
      mark_wr_en    = 1'b0;
      mark_wr_addr  = cursor_ff;
      mark_wr_data  = 1'b0;
      mark_rd_en    = 1'b0;

      unique case (state_ff)
         ltrie_pkg::ST_CLEAR: begin
            child_wr_en   = 1'b1;
            child_wr_addr = clear_ff;
            child_wr_data = '0;
            if (32'(clear_ff) < NODE_COUNT) begin
               mark_wr_en   = 1'b1;
               mark_wr_addr = NODE_W'(clear_ff);
            end
            if (32'(clear_ff) == SLOTS - 1) begin
               state_in = ltrie_pkg::ST_IDLE;
            end else begin
               clear_in = clear_ff + ADDR_W'(1);
            end
         end
         ltrie_pkg::ST_IDLE: begin
            if (accept) begin
               item_in = req_data;
               addr_in = walk_addr;
               if (walk) begin
                  child_rd_en = 1'b1;
                  state_in    = ltrie_pkg::ST_WALK;
               end else if (req_data.last) begin
                  state_in = ltrie_pkg::ST_FINISH;
               end
            end
         end
         ltrie_pkg::ST_WALK: begin
            if (child_rd_data != '0) begin
               cursor_in = child_rd_data;
            end else if (is_insert && pool_left) begin
               child_wr_en = 1'b1;
               cursor_in   = NODE_W'(free_ff);
               free_in     = free_ff + FREE_W'(1);
            end else begin
               missing_in = 1'b1;
            end
            state_in = item_ff.last ? ltrie_pkg::ST_FINISH : ltrie_pkg::ST_IDLE;
         end
         ltrie_pkg::ST_FINISH: begin
            if (is_insert || is_delete) begin
               if (out_ok) begin
                  mark_wr_en       = !missing_ff;
                  mark_wr_data     = is_insert;
                  rsp_in.found     = 1'b0;
                  rsp_in.pool_full = is_insert && missing_ff;
                  rsp_valid_in     = 1'b1;
                  cursor_in        = '0;
                  missing_in       = 1'b0;
                  state_in         = ltrie_pkg::ST_IDLE;
               end
            end else begin
               mark_rd_en = 1'b1;
               state_in   = ltrie_pkg::ST_LOOKUP;
            end
         end
         ltrie_pkg::ST_LOOKUP: begin
            if (out_ok) begin
               rsp_in.found     = !missing_ff && mark_rd_data;
               rsp_in.pool_full = 1'b0;
               rsp_valid_in     = 1'b1;
               cursor_in        = '0;
               missing_in       = 1'b0;
               state_in         = ltrie_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ltrie_pkg::ST_IDLE;
         end
      endcase
   end

   a_free_bounds: assert property (@(posedge clock) disable iff (reset)
      (free_ff != '0) && (32'(free_ff) <= NODE_COUNT))
      else $error("free node pointer out of range");

   a_cursor_allocated: assert property (@(posedge clock) disable iff (reset)
      32'(cursor_ff) < 32'(free_ff))
      else $error("cursor points at an unallocated node");

   a_result_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.found && rsp_ff.pool_full))
      else $error("result flags both set");

   a_walk_after_accept: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ltrie_pkg::ST_WALK) |-> $past(accept))
      else $error("child lookup without a transfer");

endmodule

`default_nettype wire

// ===== hw/rtl/ltrie_ram.sv =====
// simple dual-port synchronous ram with registered read data
`default_nettype none

module ltrie_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire
